@@ rtl/u8sv_pkg.sv @@
package u8sv_pkg;

	localparam logic [7:0] LEAD_ONE_LIMIT   = 8'd128;
	localparam logic [7:0] LEAD_TWO_LIMIT   = 8'd224;
	localparam logic [7:0] LEAD_THREE_LIMIT = 8'd240;
	localparam logic [7:0] CONT_MIN         = 8'h80;
	localparam logic [7:0] CONT_MAX         = 8'hBF;
	localparam logic [7:0] LEAD_MULTI_MIN   = 8'hC2;
	localparam logic [7:0] LEAD_MAX         = 8'hF4;
	localparam logic [7:0] ASCII_MAX        = 8'h7F;

	typedef enum logic [1:0] {
		ST_VALID     = 2'd0,
		ST_INVALID   = 2'd1,
		ST_TRUNCATED = 2'd2,
		ST_END_MARK  = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] packed_sequence;
		logic [15:0] start_position;
		status_t     status;
		logic        last_of_string;
	} result_t;

	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] len;
		if (lead < LEAD_ONE_LIMIT) begin
			len = 3'd1;
		end else if (lead < LEAD_TWO_LIMIT) begin
			len = 3'd2;
		end else if (lead < LEAD_THREE_LIMIT) begin
			len = 3'd3;
		end else begin
			len = 3'd4;
		end
		return len;
	endfunction

	function automatic logic seq_valid(input logic [31:0] seq, input logic [2:0] len);
		logic [7:0] lead;
		logic [7:0] cont;
		logic       ok;
		lead = seq[7:0];
		ok = !((lead > ASCII_MAX && lead < LEAD_MULTI_MIN) || lead > LEAD_MAX);
		for (int k = 1; k < 4; k++) begin
			cont = seq[8*k +: 8];
			if (3'(k) < len && (cont < CONT_MIN || cont > CONT_MAX)) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

@@ rtl/u8sv_in_if.sv @@
interface u8sv_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_string;

	modport source (output valid, output data_byte, output end_of_string, input ready);
	modport sink (input valid, input data_byte, input end_of_string, output ready);
endinterface

@@ rtl/u8sv_out_if.sv @@
interface u8sv_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] packed_sequence;
	logic [15:0] start_position;
	logic [1:0]  status;
	logic        last_of_string;

	modport source (output valid, output packed_sequence, output start_position,
		output status, output last_of_string, input ready);
	modport sink (input valid, input packed_sequence, input start_position,
		input status, input last_of_string, output ready);
endinterface

@@ rtl/u8sv_seq_core.sv @@
module u8sv_seq_core import u8sv_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	u8sv_in_if.sink  in_ch,
	output logic     res_valid,
	output result_t  res,
	input  logic     res_ready
);

	logic                     v_s1;
	logic [7:0]               byte_s1;
	logic                     eos_s1;

	logic [2:0]               exp_len_q;
	logic [2:0]               count_q;
	logic [31:0]              gathered_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [POSITION_BITS-1:0] offset_q;
	logic                     error_q;

	logic [2:0]               len_now;
	logic [2:0]               count_base;
	logic [2:0]               count_next;
	logic [31:0]              gathered_base;
	logic [31:0]              gathered_new;
	logic [POSITION_BITS-1:0] start_base;
	logic                     complete;
	logic                     has_result;
	logic                     advance;
	logic [15:0]              start_out;
	logic [15:0]              offset_out;
	logic                     start_high;
	logic                     offset_high;

	// Positions wider than the result field saturate to all ones.
	generate
		if (POSITION_BITS > 16) begin : g_sat
			assign start_high  = |start_base[POSITION_BITS-1:16];
			assign offset_high = |offset_q[POSITION_BITS-1:16];
		end else begin : g_nosat
			assign start_high  = 1'b0;
			assign offset_high = 1'b0;
		end
	endgenerate

	assign start_out  = start_high ? 16'hFFFF : 16'(start_base);
	assign offset_out = offset_high ? 16'hFFFF : 16'(offset_q);

	always_comb begin
		if (exp_len_q == 3'd0) begin
			len_now       = seq_len(byte_s1);
			count_base    = 3'd0;
			gathered_base = 32'd0;
			start_base    = offset_q;
		end else begin
			len_now       = exp_len_q;
			count_base    = count_q;
			gathered_base = gathered_q;
			start_base    = start_q;
		end
		gathered_new = gathered_base | (32'(byte_s1) << {count_base[1:0], 3'b000});
		count_next   = count_base + 3'd1;
		complete     = count_next >= len_now;
	end

	always_comb begin
		res.packed_sequence = 32'd0;
		res.start_position  = start_out;
		res.status          = ST_VALID;
		res.last_of_string  = eos_s1;
		has_result          = 1'b0;
		if (error_q) begin
			res.start_position = offset_out;
			res.status         = ST_END_MARK;
			has_result         = eos_s1;
		end else if (complete) begin
			res.packed_sequence = gathered_new;
			res.status          = seq_valid(gathered_new, len_now) ? ST_VALID : ST_INVALID;
			has_result          = 1'b1;
		end else begin
			// A string ending inside an open sequence reports truncation.
			res.status = ST_TRUNCATED;
			has_result = eos_s1;
		end
	end

	assign res_valid   = v_s1 && has_result;
	assign advance     = v_s1 && (!has_result || res_ready);
	assign in_ch.ready = !v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			byte_s1 <= in_ch.data_byte;
			eos_s1  <= in_ch.end_of_string;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_len_q  <= 3'd0;
			count_q    <= 3'd0;
			gathered_q <= 32'd0;
			start_q    <= '0;
			offset_q   <= '0;
			error_q    <= 1'b0;
		end else if (advance) begin
			if (eos_s1) begin
				exp_len_q  <= 3'd0;
				count_q    <= 3'd0;
				gathered_q <= 32'd0;
				start_q    <= '0;
				offset_q   <= '0;
				error_q    <= 1'b0;
			end else begin
				if (offset_q != '1) begin
					offset_q <= offset_q + POSITION_BITS'(1);
				end
				if (!error_q) begin
					if (complete) begin
						exp_len_q  <= 3'd0;
						count_q    <= 3'd0;
						gathered_q <= 32'd0;
						error_q    <= !seq_valid(gathered_new, len_now);
					end else begin
						exp_len_q  <= len_now;
						count_q    <= count_next;
						gathered_q <= gathered_new;
					end
					start_q <= start_base;
				end
			end
		end
	end

endmodule

@@ rtl/u8sv_out_reg.sv @@
module u8sv_out_reg import u8sv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       res_valid,
	input  result_t    res,
	output logic       res_ready,
	u8sv_out_if.source out_ch
);

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	assign out_ch.valid           = valid_q;
	assign out_ch.packed_sequence = res_q.packed_sequence;
	assign out_ch.start_position  = res_q.start_position;
	assign out_ch.status          = res_q.status;
	assign out_ch.last_of_string  = res_q.last_of_string;

endmodule

@@ rtl/utf8_sequence_splitter_validator.sv @@
// Channel  Dir  Payload                                                  Handshake
// in_ch    in   data_byte[7:0], end_of_string                            valid/ready
// out_ch   out  packed_sequence[31:0], start_position[15:0], status[1:0], valid/ready
//               last_of_string
//
// One item is accepted per cycle while in_ch.ready is high; a result reaches the output
// through the input register, then the result register.
// Reset clears all string state at once; no clearing pass is needed.
// While a result waits in the output register, bytes that yield no result keep
// flowing; in_ch.ready drops only when a byte with a result meets a full, stalled output.
module utf8_sequence_splitter_validator import u8sv_pkg::*; #(
	parameter int POSITION_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	u8sv_in_if.sink    in_ch,
	u8sv_out_if.source out_ch
);

	logic    res_valid;
	logic    res_ready;
	result_t res;

	u8sv_seq_core #(
		.POSITION_BITS(POSITION_BITS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	u8sv_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready),
		.out_ch    (out_ch)
	);

endmodule

@@ rtl/u8sv_checker.sv @@
module u8sv_checker import u8sv_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [31:0] packed_sequence,
	input logic [1:0]  status,
	input logic        last_of_string
);

	// Truncation and end markers carry no bytes.
	a_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TRUNCATED || status == ST_END_MARK)
		|-> packed_sequence == 32'd0)
		else $error("truncated or end marker result carries bytes");

	// Only the last byte of a string can produce these results.
	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_TRUNCATED || status == ST_END_MARK)
		|-> last_of_string)
		else $error("truncated or end marker result without last flag");

	// A sequence reported valid has an acceptable lead byte.
	a_valid_lead: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_VALID
		|-> !((packed_sequence[7:0] > ASCII_MAX && packed_sequence[7:0] < LEAD_MULTI_MIN)
			|| packed_sequence[7:0] > LEAD_MAX))
		else $error("valid result with a bad lead byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(packed_sequence)
			&& $stable(status) && $stable(last_of_string))
		else $error("stalled result changed");

endmodule

bind utf8_sequence_splitter_validator u8sv_checker u_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.out_valid       (out_ch.valid),
	.out_ready       (out_ch.ready),
	.packed_sequence (out_ch.packed_sequence),
	.status          (out_ch.status),
	.last_of_string  (out_ch.last_of_string)
);

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import u8sv_pkg::*;

	localparam int          POSITION_BITS = 16;
	localparam int unsigned OFFSET_MAX    = (1 << POSITION_BITS) - 1;
	localparam int unsigned RANDOM_BYTES  = 1080;
	localparam int unsigned HOLD_CYCLES   = 80;
	localparam int unsigned CYCLE_LIMIT   = 2_000_000;

	typedef logic [7:0] byte_q_t[$];
	typedef enum {RX_STEADY, RX_RANDOM, RX_PERIODIC} rx_mode_t;

	class utf8_split_tracker;
		result_t     pending_sequences[$];
		int unsigned mismatches;
		int unsigned open_length;
		int unsigned gathered_count;
		logic [31:0] gathered_word;
		int unsigned open_start;
		int unsigned offset;
		bit          string_broken;

		function new();
			mismatches = 0;
			clear_string();
		endfunction

		function void clear_string();
			open_length = 0;
			gathered_count = 0;
			gathered_word = '0;
			open_start = 0;
			offset = 0;
			string_broken = 0;
		endfunction

		function logic [15:0] out_position(int unsigned pos);
			return (pos > 32'hFFFF) ? 16'hFFFF : 16'(pos);
		endfunction

		function void accept_byte(logic [7:0] b, logic eos);
			result_t     r;
			bit          produced;
			bit          well;
			logic [7:0]  c;
			int unsigned pos;
			pos = offset;
			produced = 0;
			r = '0;
			if (string_broken) begin
				// The rest of a broken string is dropped until its last byte.
				if (eos) begin
					r.start_position = out_position(pos);
					r.status = ST_END_MARK;
					r.last_of_string = 1'b1;
					produced = 1;
				end
			end else begin
				if (open_length == 0) begin
					if (b < 8'd128) open_length = 1;
					else if (b < 8'd224) open_length = 2;
					else if (b < 8'd240) open_length = 3;
					else open_length = 4;
					gathered_count = 0;
					gathered_word = '0;
					open_start = pos;
				end
				gathered_word[8*gathered_count +: 8] = b;
				gathered_count++;
				if (gathered_count >= open_length) begin
					well = !((gathered_word[7:0] > 8'h7F && gathered_word[7:0] < 8'hC2) ||
						gathered_word[7:0] > 8'hF4);
					for (int k = 1; k < open_length; k++) begin
						c = gathered_word[8*k +: 8];
						if (c < 8'h80 || c > 8'hBF) well = 0;
					end
					r.packed_sequence = gathered_word;
					r.start_position = out_position(open_start);
					r.status = well ? ST_VALID : ST_INVALID;
					r.last_of_string = eos;
					produced = 1;
					if (!well) string_broken = 1;
					open_length = 0;
					gathered_count = 0;
					gathered_word = '0;
				end else if (eos) begin
					r.start_position = out_position(open_start);
					r.status = ST_TRUNCATED;
					r.last_of_string = 1'b1;
					produced = 1;
				end
			end
			if (produced) pending_sequences = {pending_sequences, r};
			if (eos) clear_string();
			else if (offset < OFFSET_MAX) offset++;
		endfunction

		function void compare_sequence(result_t got);
			result_t want;
			if (pending_sequences.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: packed %h pos %0d status %0d last %0b",
						got.packed_sequence, got.start_position, got.status,
						got.last_of_string);
				return;
			end
			want = pending_sequences.pop_front();
			if (got.packed_sequence !== want.packed_sequence ||
					got.start_position !== want.start_position ||
					got.status !== want.status ||
					got.last_of_string !== want.last_of_string) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected %h/%0d/%0d/%0b got %h/%0d/%0d/%0b",
						want.packed_sequence, want.start_position, want.status,
						want.last_of_string, got.packed_sequence, got.start_position,
						got.status, got.last_of_string);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	u8sv_in_if  in_ch();
	u8sv_out_if out_ch();

	utf8_sequence_splitter_validator #(
		.POSITION_BITS(POSITION_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	utf8_split_tracker tracker = new();
	int unsigned       burst_left = 0;
	int unsigned       bytes_sent = 0;
	int unsigned       cycle_count = 0;
	bit                hold_req = 0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("utf8_sequence_splitter_validator test failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		result_t got;
		if (arst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			got.packed_sequence = out_ch.packed_sequence;
			got.start_position = out_ch.start_position;
			got.status = status_t'(out_ch.status);
			got.last_of_string = out_ch.last_of_string;
			tracker.compare_sequence(got);
		end
	end

	// Receiver: switches between steady, random and periodic acceptance, and
	// honors a long hold-off when the sender asks for one.
	initial begin
		rx_mode_t    mode;
		int unsigned mode_left;
		int unsigned period;
		int unsigned phase;
		mode = RX_STEADY;
		mode_left = 0;
		period = 2;
		phase = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 0;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(50, 300);
					period = $urandom_range(2, 4);
				end
				mode_left--;
				phase++;
				case (mode)
				RX_STEADY: out_ch.ready = 1'b1;
				RX_RANDOM: out_ch.ready = ($urandom_range(0, 3) != 0);
				default: out_ch.ready = (phase % period == 0);
				endcase
			end
		end
	end

	function automatic byte_q_t utf8_sequence(int unsigned len);
		byte_q_t s;
		case (len)
		1: s = {s, 8'($urandom_range(8'h00, 8'h7F))};
		2: s = {s, 8'($urandom_range(8'hC2, 8'hDF))};
		3: s = {s, 8'($urandom_range(8'hE0, 8'hEF))};
		default: s = {s, 8'($urandom_range(8'hF0, 8'hF4))};
		endcase
		repeat (len - 1) s = {s, 8'($urandom_range(8'h80, 8'hBF))};
		return s;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic eos);
		int unsigned gap;
		if (burst_left == 0) begin
			if ($urandom_range(0, 4) == 0) begin
				burst_left = $urandom_range(50, 200);
				gap = 0;
			end else begin
				burst_left = $urandom_range(1, 16);
				gap = $urandom_range(0, 6);
			end
			if (gap != 0) begin
				in_ch.valid = 1'b0;
				in_ch.data_byte = 8'($urandom);
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_ch.valid = 1'b1;
		in_ch.data_byte = b;
		in_ch.end_of_string = eos;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		tracker.accept_byte(b, eos);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_string(input byte_q_t text);
		foreach (text[i]) send_byte(text[i], i == text.size() - 1);
	endtask

	task automatic wait_drained();
		in_ch.valid = 1'b0;
		while (tracker.pending_sequences.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		byte_q_t     text;
		byte_q_t     piece;
		int unsigned pick;
		int unsigned random_end;
		bit          pressure_done;
		pressure_done = 0;
		in_ch.valid = 1'b0;
		in_ch.data_byte = 8'h00;
		in_ch.end_of_string = 1'b0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// ASCII extremes, then valid two-byte extremes.
		send_string('{8'h00, 8'h7F});
		send_string('{8'hC2, 8'h80, 8'hDF, 8'hBF});
		// Overlong three-byte form passes.
		send_string('{8'hE0, 8'h80, 8'h80});
		// Surrogate and overlong four-byte form pass.
		send_string('{8'hED, 8'hA0, 8'h80, 8'hF0, 8'h80, 8'h80, 8'h80});
		// Bad lead completed by the last byte: the invalid item itself closes the string.
		send_string('{8'hC0, 8'h80});
		// Truncation wins over a bad continuation already gathered.
		send_string('{8'hE2, 8'h28});
		// Stray continuation as lead, then the end marker.
		send_string('{8'h80, 8'h41, 8'h41});
		// Highest lead left open at the end.
		send_string('{8'h41, 8'hFF});

		random_end = bytes_sent + RANDOM_BYTES;
		while (bytes_sent < random_end) begin
			text = {};
			repeat ($urandom_range(1, 10)) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					text = {text, utf8_sequence($urandom_range(1, 4))};
				end else if (pick < 9) begin
					repeat ($urandom_range(1, 4)) text = {text, 8'($urandom)};
				end else begin
					piece = utf8_sequence($urandom_range(2, 4));
					piece[$urandom_range(1, piece.size() - 1)] = $urandom_range(0, 1) ?
						8'($urandom_range(8'h00, 8'h7F)) : 8'($urandom_range(8'hC0, 8'hFF));
					text = {text, piece};
				end
			end
			if ($urandom_range(0, 3) == 0) begin
				text = {text, 8'($urandom_range(8'hC0, 8'hFF))};
				if ($urandom_range(0, 1)) text = {text, 8'($urandom_range(8'h80, 8'hBF))};
			end
			send_string(text);

			// Halfway: stall the receiver under a run of ASCII so the input backs
			// up, then let everything drain before going on.
			if (!pressure_done && bytes_sent >= random_end - RANDOM_BYTES / 2) begin
				pressure_done = 1;
				hold_req = 1;
				text = {};
				repeat (40) text = {text, 8'($urandom_range(8'h00, 8'h7F))};
				send_string(text);
				wait_drained();
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.pending_sequences.size() == 0) begin
			$display("utf8_sequence_splitter_validator test passed");
		end else begin
			$display("utf8_sequence_splitter_validator test failed");
		end
		$finish;
	end

endmodule
